// ----- rtl/zrh_pkg.sv -----
// Shared widths, register indexes and types of the zone region histogram block.
// No dependencies; used by every module under rtl.
package zrh_pkg;

  localparam int COORD_W     = 10;
  localparam int SPAN_W      = 11;
  localparam int ZONE_W      = 4;
  localparam int COUNT_W     = 21;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 4;
  localparam int NUM_ZONES_DEFAULT = 16;
  localparam int MAX_REGION_SIDE   = 1024;
  localparam int MAX_REPORT        = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXTURE_WIDTH  = 4'd0,
    REG_TEXTURE_HEIGHT = 4'd1,
    REG_ORIGIN_X       = 4'd2,
    REG_ORIGIN_Y       = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] texture_width;
    logic [CFG_W-1:0] texture_height;
    logic [CFG_W-1:0] origin_x;
    logic [CFG_W-1:0] origin_y;
  } cfg_t;

  typedef struct packed {
    logic              found;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [SPAN_W-1:0]  width;
    logic [SPAN_W-1:0]  height;
  } box_t;

endpackage

// ----- rtl/zrh_accum.sv -----
// Per-zone pixel counters and bounding box of one region.
// Depends on zrh_pkg; hands a snapshot to zrh_drain at the end of a region.
module zrh_accum #(
  parameter int NUM_ZONES = zrh_pkg::NUM_ZONES_DEFAULT,
  parameter int LANES     = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [zrh_pkg::COORD_W-1:0]  local_x,
  input  logic [zrh_pkg::COORD_W-1:0]  local_y,
  input  logic [zrh_pkg::ZONE_W-1:0]   zone_label,
  input  logic                         end_of_region,
  input  zrh_pkg::cfg_t                cfg,
  output logic                         load,
  output logic [LANES-1:0][zrh_pkg::COUNT_W-1:0] counts_snap,
  output zrh_pkg::box_t                box_snap
);

  logic [LANES-1:0][zrh_pkg::COUNT_W-1:0] counts;
  logic [LANES-1:0][zrh_pkg::COUNT_W-1:0] counts_next;
  logic [zrh_pkg::COORD_W-1:0] min_col, max_col, min_row, max_row;
  logic [zrh_pkg::COORD_W-1:0] min_col_next, max_col_next, min_row_next, max_row_next;
  logic seen_any, seen_any_next;
  logic [zrh_pkg::CFG_W:0] tx, ty;
  logic in_x, in_y, in_side, zone_ok, hit;

  // Texture position in 14 bits; the top bit is the sign
  assign tx = (zrh_pkg::CFG_W+1)'(local_x) + {cfg.origin_x[zrh_pkg::CFG_W-1], cfg.origin_x};
  assign ty = (zrh_pkg::CFG_W+1)'(local_y) + {cfg.origin_y[zrh_pkg::CFG_W-1], cfg.origin_y};
  assign in_x = !tx[zrh_pkg::CFG_W] && (tx[zrh_pkg::CFG_W-1:0] < cfg.texture_width);
  assign in_y = !ty[zrh_pkg::CFG_W] && (ty[zrh_pkg::CFG_W-1:0] < cfg.texture_height);
  assign in_side = (zrh_pkg::CFG_W'(local_x) < zrh_pkg::CFG_W'(zrh_pkg::MAX_REGION_SIDE)) &&
                   (zrh_pkg::CFG_W'(local_y) < zrh_pkg::CFG_W'(zrh_pkg::MAX_REGION_SIDE));
  assign zone_ok = (zone_label != '0) && (32'(zone_label) < NUM_ZONES);
  assign hit = in_x && in_y && in_side && zone_ok;

  // Lane i counts zone i+1; saturate at the top value
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      counts_next[i] = counts[i];
      if (hit && (zone_label == zrh_pkg::ZONE_W'(i + 1)) && (counts[i] != zrh_pkg::COUNT_MAX))
        counts_next[i] = counts[i] + 1'b1;
    end
  end

  always_comb begin
    min_col_next  = min_col;
    max_col_next  = max_col;
    min_row_next  = min_row;
    max_row_next  = max_row;
    seen_any_next = seen_any;
    if (hit) begin
      seen_any_next = 1'b1;
      if (!seen_any) begin
        min_col_next = local_x;
        max_col_next = local_x;
        min_row_next = local_y;
        max_row_next = local_y;
      end else begin
        if (local_x < min_col) min_col_next = local_x;
        if (local_x > max_col) max_col_next = local_x;
        if (local_y < min_row) min_row_next = local_y;
        if (local_y > max_row) max_row_next = local_y;
      end
    end
  end

  assign load        = step && end_of_region;
  assign counts_snap = counts_next;

  always_comb begin
    box_snap = '0;
    if (seen_any_next) begin
      box_snap.found  = 1'b1;
      box_snap.left   = min_col_next;
      box_snap.top    = min_row_next;
      box_snap.width  = zrh_pkg::SPAN_W'(max_col_next) - zrh_pkg::SPAN_W'(min_col_next) + 1'b1;
      box_snap.height = zrh_pkg::SPAN_W'(max_row_next) - zrh_pkg::SPAN_W'(min_row_next) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counts   <= '0;
      seen_any <= 1'b0;
      min_col  <= '0;
      max_col  <= '0;
      min_row  <= '0;
      max_row  <= '0;
    end else if (step) begin
      if (end_of_region) begin
        // clear for the next region
        counts   <= '0;
        seen_any <= 1'b0;
        min_col  <= '0;
        max_col  <= '0;
        min_row  <= '0;
        max_row  <= '0;
      end else begin
        counts   <= counts_next;
        seen_any <= seen_any_next;
        min_col  <= min_col_next;
        max_col  <= max_col_next;
        min_row  <= min_row_next;
        max_row  <= max_row_next;
      end
    end
  end

endmodule

// ----- rtl/zrh_drain.sv -----
// Result shift line: holds the snapshot of one region and hands out one zone a cycle
// while out_ready is high. Depends on zrh_pkg; loaded from zrh_accum.
module zrh_drain #(
  parameter int LANES = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [LANES-1:0][zrh_pkg::COUNT_W-1:0] counts_snap,
  input  zrh_pkg::box_t                box_snap,
  output logic                         can_load,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [zrh_pkg::ZONE_W-1:0]   zone_index,
  output logic [zrh_pkg::COUNT_W-1:0]  zone_total,
  output logic                         any_found,
  output logic [zrh_pkg::COORD_W-1:0]  box_left,
  output logic [zrh_pkg::COORD_W-1:0]  box_top,
  output logic [zrh_pkg::SPAN_W-1:0]   box_width,
  output logic [zrh_pkg::SPAN_W-1:0]   box_height,
  output logic                         final_result
);

  logic [LANES-1:0][zrh_pkg::COUNT_W-1:0] snap;
  zrh_pkg::box_t                  box;
  logic                           active;
  logic [zrh_pkg::ZONE_W-1:0]     idx;
  logic                           take;

  assign take         = active && out_ready;
  assign final_result = (idx == zrh_pkg::ZONE_W'(LANES));
  assign can_load     = !active || (final_result && out_ready);

  assign out_valid  = active;
  assign zone_index = idx;
  assign zone_total = snap[0];
  assign any_found  = box.found;
  assign box_left   = box.left;
  assign box_top    = box.top;
  assign box_width  = box.width;
  assign box_height = box.height;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= zrh_pkg::ZONE_W'(1);
    end else if (load) begin
      active <= 1'b1;
      idx    <= zrh_pkg::ZONE_W'(1);
    end else if (take) begin
      if (final_result) active <= 1'b0;
      idx <= idx + 1'b1;
    end
  end

  // Payload: load the snapshot, advance one lane per taken item
  always_ff @(posedge clk) begin
    if (load) begin
      snap <= counts_snap;
      box  <= box_snap;
    end else if (take) begin
      for (int k = 0; k < LANES - 1; k++) snap[k] <= snap[k+1];
    end
  end

endmodule

// ----- rtl/zone_region_histogram_bbox_unit.sv -----
// Top level of the zone region histogram and bounding box block.
// Depends on zrh_pkg, zrh_accum and zrh_drain.
//
// Takes one labelled pixel per clock on the in channel while in_ready is high. A pixel
// counts when its texture position lies inside the texture, its local position is below
// the region limit and its zone code is nonzero and below NUM_ZONES. Each pixel passes
// an input register and updates its zone's counter and the box, so the sustained rate
// is one pixel a cycle and a pixel reaches the counters in the cycle after it is
// accepted. On a pixel marked end_of_region the counters are copied into a result shift
// line and cleared at once; the first result is ready once the end mark has left the
// input register, and min(NUM_ZONES,16)-1 results then leave one per cycle as out_ready
// allows, zone 1 first, final_result on the last. Pixels of the next region are taken
// while those results drain; only a further end mark waits, in the input register,
// until the previous region's last result is taken, so regions shorter than the result
// count or a stalling receiver throttle the input. No clearing pass is needed after
// reset. Configuration must be written only while the block is idle; it is not checked.
module zone_region_histogram_bbox_unit #(
  parameter int NUM_ZONES = zrh_pkg::NUM_ZONES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [zrh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [zrh_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [zrh_pkg::COORD_W-1:0]   local_x,
  input  logic [zrh_pkg::COORD_W-1:0]   local_y,
  input  logic [zrh_pkg::ZONE_W-1:0]    zone_label,
  input  logic                          end_of_region,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [zrh_pkg::ZONE_W-1:0]    zone_index,
  output logic [zrh_pkg::COUNT_W-1:0]   zone_total,
  output logic                          any_found,
  output logic [zrh_pkg::COORD_W-1:0]   box_left,
  output logic [zrh_pkg::COORD_W-1:0]   box_top,
  output logic [zrh_pkg::SPAN_W-1:0]    box_width,
  output logic [zrh_pkg::SPAN_W-1:0]    box_height,
  output logic                          final_result
);

  localparam int REPORT = (NUM_ZONES < zrh_pkg::MAX_REPORT) ? NUM_ZONES : zrh_pkg::MAX_REPORT;
  localparam int LANES  = REPORT - 1;

  zrh_pkg::cfg_t cfg;

  logic                        s1_valid;
  logic [zrh_pkg::COORD_W-1:0] s1_x, s1_y;
  logic [zrh_pkg::ZONE_W-1:0]  s1_zone;
  logic                        s1_eor;
  logic                        s1_adv, step, in_take, can_load, load;
  logic [LANES-1:0][zrh_pkg::COUNT_W-1:0] counts_snap;
  zrh_pkg::box_t               box_snap;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        zrh_pkg::REG_TEXTURE_WIDTH:  cfg.texture_width  <= cfg_data;
        zrh_pkg::REG_TEXTURE_HEIGHT: cfg.texture_height <= cfg_data;
        zrh_pkg::REG_ORIGIN_X:       cfg.origin_x       <= cfg_data;
        zrh_pkg::REG_ORIGIN_Y:       cfg.origin_y       <= cfg_data;
        default: ;
      endcase
    end
  end

  // An end mark holds in the input register until the result line is free
  assign s1_adv   = !s1_eor || can_load;
  assign step     = s1_valid && s1_adv;
  assign in_ready = !s1_valid || s1_adv;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_x    <= local_x;
      s1_y    <= local_y;
      s1_zone <= zone_label;
      s1_eor  <= end_of_region;
    end
  end

  zrh_accum #(
    .NUM_ZONES(NUM_ZONES),
    .LANES(LANES)
  ) u_accum (
    .clk(clk),
    .rst(rst),
    .step(step),
    .local_x(s1_x),
    .local_y(s1_y),
    .zone_label(s1_zone),
    .end_of_region(s1_eor),
    .cfg(cfg),
    .load(load),
    .counts_snap(counts_snap),
    .box_snap(box_snap)
  );

  zrh_drain #(
    .LANES(LANES)
  ) u_drain (
    .clk(clk),
    .rst(rst),
    .load(load),
    .counts_snap(counts_snap),
    .box_snap(box_snap),
    .can_load(can_load),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .zone_index(zone_index),
    .zone_total(zone_total),
    .any_found(any_found),
    .box_left(box_left),
    .box_top(box_top),
    .box_width(box_width),
    .box_height(box_height),
    .final_result(final_result)
  );

`ifndef SYNTHESIS
  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !final_result |=>
      out_valid && (zone_index == zrh_pkg::ZONE_W'($past(zone_index) + 1'b1)))
    else $error("zone index did not advance by one");

  a_empty_box: assert property (@(posedge clk) disable iff (rst)
    out_valid && !any_found |->
      (box_left == '0) && (box_top == '0) && (box_width == '0) && (box_height == '0))
    else $error("box not zero for an empty region");

  a_end_waits: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_eor && out_valid && !final_result |-> !in_ready)
    else $error("end of region passed while results still drain");

  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && final_result && !load |=> !out_valid)
    else $error("results kept coming after the final one");
`endif

endmodule

// ----- tb/tb_zone_region_histogram_bbox_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of zone_region_histogram_bbox_unit: streams labelled pixels,
// predicts per-zone counts and the bounding box of each region and checks every result.
// Depends on zrh_pkg and the block's RTL.
module tb_zone_region_histogram_bbox_unit;

  localparam int CLK_HALF     = 5;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int CFG_REGS     = 4;
  localparam int PHASE_PIXELS = 54;
  localparam int REPORT_ZONES = (zrh_pkg::NUM_ZONES_DEFAULT < zrh_pkg::MAX_REPORT) ?
                                zrh_pkg::NUM_ZONES_DEFAULT : zrh_pkg::MAX_REPORT;

  typedef struct {
    logic [zrh_pkg::ZONE_W-1:0]  zone;
    logic [zrh_pkg::COUNT_W-1:0] total;
    logic                        found;
    logic [zrh_pkg::COORD_W-1:0] left;
    logic [zrh_pkg::COORD_W-1:0] top;
    logic [zrh_pkg::SPAN_W-1:0]  width;
    logic [zrh_pkg::SPAN_W-1:0]  height;
    logic                        last;
  } zone_report_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [zrh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [zrh_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [zrh_pkg::COORD_W-1:0]   local_x = '0;
  logic [zrh_pkg::COORD_W-1:0]   local_y = '0;
  logic [zrh_pkg::ZONE_W-1:0]    zone_label = '0;
  logic                          end_of_region = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [zrh_pkg::ZONE_W-1:0]    zone_index;
  logic [zrh_pkg::COUNT_W-1:0]   zone_total;
  logic                          any_found;
  logic [zrh_pkg::COORD_W-1:0]   box_left;
  logic [zrh_pkg::COORD_W-1:0]   box_top;
  logic [zrh_pkg::SPAN_W-1:0]    box_width;
  logic [zrh_pkg::SPAN_W-1:0]    box_height;
  logic                          final_result;

  // predictor state and its copy of the registers
  logic [zrh_pkg::COUNT_W-1:0]      zone_tally [zrh_pkg::NUM_ZONES_DEFAULT];
  logic [zrh_pkg::COORD_W-1:0]      col_lo, col_hi, row_lo, row_hi;
  logic                             seen_pixel;
  logic [zrh_pkg::CFG_W-1:0]        tex_w = '0;
  logic [zrh_pkg::CFG_W-1:0]        tex_h = '0;
  logic signed [zrh_pkg::CFG_W-1:0] org_x = '0;
  logic signed [zrh_pkg::CFG_W-1:0] org_y = '0;

  zone_report_t expected_reports [$];
  zone_report_t oldest_report;
  int fail_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int pixels_sent = 0;
  int cycle_count = 0;

  zone_region_histogram_bbox_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .local_x(local_x), .local_y(local_y), .zone_label(zone_label),
    .end_of_region(end_of_region),
    .out_valid(out_valid), .out_ready(out_ready),
    .zone_index(zone_index), .zone_total(zone_total), .any_found(any_found),
    .box_left(box_left), .box_top(box_top), .box_width(box_width),
    .box_height(box_height), .final_result(final_result)
  );

  always #CLK_HALF clk = ~clk;

  function automatic void clear_tally();
    for (int z = 0; z < zrh_pkg::NUM_ZONES_DEFAULT; z++) zone_tally[z] = '0;
    col_lo = '0;
    col_hi = '0;
    row_lo = '0;
    row_hi = '0;
    seen_pixel = 1'b0;
  endfunction

  function automatic void tally_pixel(input logic [zrh_pkg::COORD_W-1:0] lx,
                                      input logic [zrh_pkg::COORD_W-1:0] ly,
                                      input logic [zrh_pkg::ZONE_W-1:0] zone,
                                      input logic last);
    int tx, ty;
    zone_report_t rep;
    tx = int'(lx) + int'(org_x);
    ty = int'(ly) + int'(org_y);
    if (tx >= 0 && ty >= 0 && tx < int'(tex_w) && ty < int'(tex_h) &&
        zone != '0 && int'(zone) < zrh_pkg::NUM_ZONES_DEFAULT) begin
      if (!seen_pixel) begin
        col_lo = lx;
        col_hi = lx;
        row_lo = ly;
        row_hi = ly;
        seen_pixel = 1'b1;
      end else begin
        if (lx < col_lo) col_lo = lx;
        if (lx > col_hi) col_hi = lx;
        if (ly < row_lo) row_lo = ly;
        if (ly > row_hi) row_hi = ly;
      end
      if (zone_tally[zone] != zrh_pkg::COUNT_MAX) zone_tally[zone] = zone_tally[zone] + 1'b1;
    end
    if (last) begin
      for (int z = 1; z < REPORT_ZONES; z++) begin
        rep.zone   = zrh_pkg::ZONE_W'(z);
        rep.total  = zone_tally[z];
        rep.found  = seen_pixel;
        rep.left   = seen_pixel ? col_lo : '0;
        rep.top    = seen_pixel ? row_lo : '0;
        rep.width  = seen_pixel ? ({1'b0, col_hi} - {1'b0, col_lo} + 1'b1) : '0;
        rep.height = seen_pixel ? ({1'b0, row_hi} - {1'b0, row_lo} + 1'b1) : '0;
        rep.last   = (z + 1 == REPORT_ZONES);
        expected_reports.push_back(rep);
      end
      clear_tally();
    end
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) tally_pixel(local_x, local_y, zone_label, end_of_region);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $error("zone_index: expected no result, actual %0d", zone_index);
        fail_count++;
      end else begin
        oldest_report = expected_reports.pop_front();
        compare_field("zone_index", oldest_report.zone, zone_index);
        compare_field("zone_total", oldest_report.total, zone_total);
        compare_field("any_found", oldest_report.found, any_found);
        compare_field("box_left", oldest_report.left, box_left);
        compare_field("box_top", oldest_report.top, box_top);
        compare_field("box_width", oldest_report.width, box_width);
        compare_field("box_height", oldest_report.height, box_height);
        compare_field("final_result", oldest_report.last, final_result);
      end
    end
  end

  // receiver: a long hold-off takes precedence over random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_pixel(input int lx, input int ly, input logic [zrh_pkg::ZONE_W-1:0] zone,
                            input logic last);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    local_x = zrh_pkg::COORD_W'(lx);
    local_y = zrh_pkg::COORD_W'(ly);
    zone_label = zone;
    end_of_region = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid, wait for every expected result, then let the pipeline settle
  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_reg(input logic [zrh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [zrh_pkg::CFG_W-1:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    case (idx)
      zrh_pkg::REG_TEXTURE_WIDTH:  tex_w = value;
      zrh_pkg::REG_TEXTURE_HEIGHT: tex_h = value;
      zrh_pkg::REG_ORIGIN_X:       org_x = value;
      zrh_pkg::REG_ORIGIN_Y:       org_y = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_texture(input int w, input int h, input int ox, input int oy);
    program_reg(zrh_pkg::REG_TEXTURE_WIDTH, zrh_pkg::CFG_W'(w));
    program_reg(zrh_pkg::REG_TEXTURE_HEIGHT, zrh_pkg::CFG_W'(h));
    program_reg(zrh_pkg::REG_ORIGIN_X, zrh_pkg::CFG_W'(ox));
    program_reg(zrh_pkg::REG_ORIGIN_Y, zrh_pkg::CFG_W'(oy));
  endtask

  function automatic logic [zrh_pkg::ZONE_W-1:0] pick_zone();
    return ($urandom_range(3) == 0) ? '0 : zrh_pkg::ZONE_W'($urandom_range(15, 1));
  endfunction

  // region start: near the origin, anywhere, or hard against the far edge
  function automatic int region_base(input int span);
    case ($urandom_range(2))
      0:       return $urandom_range(48);
      1:       return $urandom_range(zrh_pkg::MAX_REGION_SIDE - span);
      default: return zrh_pkg::MAX_REGION_SIDE - span - int'($urandom_range(6));
    endcase
  endfunction

  // scan a w x h block; without close the region runs on into the next one
  task automatic send_region(input int w, input int h, input int bx, input int by,
                             input logic close);
    for (int py = 0; py < h; py++) begin
      for (int px = 0; px < w; px++) begin
        send_pixel(bx + px, by + py, pick_zone(), close && px == w - 1 && py == h - 1);
        pixels_sent++;
      end
    end
  endtask

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    // texture of zero size: nothing can count
    send_pixel(5, 5, 4'd3, 1'b1);
    quiesce();
    set_texture(4096, 4096, 0, 0);
    send_pixel(0, 0, 4'd1, 1'b0);
    send_pixel(1023, 1023, 4'd15, 1'b0);
    send_pixel(10, 20, 4'd0, 1'b0);
    send_pixel(512, 3, 4'd15, 1'b1);
    send_pixel(7, 7, 4'd0, 1'b1);
    send_pixel(1023, 0, 4'd8, 1'b1);
    quiesce();
    // extreme origins; writes to unused indexes must change nothing
    set_texture(4096, 4096, -4096, 4095);
    program_reg(zrh_pkg::CFG_IDX_W'(CFG_REGS + $urandom_range(11)),
                zrh_pkg::CFG_W'($urandom));
    program_reg(zrh_pkg::CFG_IDX_W'(CFG_REGS + $urandom_range(11)),
                zrh_pkg::CFG_W'($urandom));
    send_pixel(1023, 0, 4'd2, 1'b1);
    send_pixel(0, 1023, 4'd2, 1'b1);
    quiesce();
    // right edge at column 4095 and a row above the texture
    set_texture(4096, 4096, 3073, -1);
    send_pixel(1022, 1, 4'd4, 1'b0);
    send_pixel(1023, 1, 4'd5, 1'b0);
    send_pixel(100, 0, 4'd6, 1'b0);
    send_pixel(1022, 1023, 4'd4, 1'b1);
    quiesce();
    set_texture(1, 1, 0, 0);
    send_pixel(0, 0, 4'd9, 1'b0);
    send_pixel(1, 0, 4'd9, 1'b0);
    send_pixel(0, 1, 4'd9, 1'b1);
    quiesce();
  endtask

  task automatic test_random_regions();
    int pick, w, h;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          set_texture(4096, 4096, 0, 0);
        end
        1: begin
          idle_pct = 70;
          stall_pct = 0;
          set_texture($urandom_range(64, 8), $urandom_range(64, 8),
                      int'($urandom_range(48)) - 32, int'($urandom_range(48)) - 32);
        end
        2: begin
          idle_pct = 0;
          stall_pct = 70;
          set_texture(4096, $urandom_range(1030, 900), 3072 + int'($urandom_range(8)),
                      -int'($urandom_range(8)));
        end
        default: begin
          idle_pct = 28;
          stall_pct = 28;
          set_texture($urandom_range(4096, 40), $urandom_range(4096, 40),
                      int'($urandom_range(40)) - 20, int'($urandom_range(40)) - 20);
        end
      endcase
      pixels_sent = 0;
      while (pixels_sent < PHASE_PIXELS) begin
        pick = $urandom_range(9);
        w = $urandom_range(5, 1);
        h = $urandom_range(4, 1);
        if (pick < 7) begin
          send_region(w, h, region_base(w), region_base(h), 1'b1);
        end else if (pick == 7) begin
          send_region(w, h, region_base(w), region_base(h), 1'b0);
        end else begin
          send_pixel($urandom_range(1023), $urandom_range(1023),
                     zrh_pkg::ZONE_W'($urandom_range(15)), $urandom_range(7) == 0);
        end
      end
      quiesce();
    end
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    set_texture(4096, 4096, 0, 0);
    // hold the receiver off so a second end mark backs up into the input
    hold_left = 200;
    for (int r = 0; r < 4; r++) send_region(4, 2, region_base(4), region_base(2), 1'b1);
    quiesce();
    stall_pct = 70;
    for (int r = 0; r < 3; r++) begin
      send_region($urandom_range(5, 1), $urandom_range(4, 1), region_base(5), region_base(4),
                  1'b1);
    end
    quiesce();
  endtask

  initial begin
    clear_tally();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_regions();
    test_backpressure();
    quiesce();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
